/* rtl/windowed_median_filter_macros.svh */
// Assertion helpers, sampled on clk, disabled during reset.
`ifndef WINDOWED_MEDIAN_FILTER_MACROS_SVH
`define WINDOWED_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication.
`define WMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmf assertion failed");

// Next-cycle implication.
`define WMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmf assertion failed");

`endif

/* rtl/wmf_pkg.sv */
package wmf_pkg;

  localparam int MAX_RADIUS_D = 7;
  localparam int MAX_WIDTH_D  = 1024;
  localparam int PIXEL_BITS_D = 8;

  localparam int RAD_W     = 3;
  localparam int IMGW_W    = 11;
  localparam int IMGH_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = 12;
  localparam int ROW_W     = 17;
  localparam int CNT_W     = 8;

  localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd3;
  localparam logic [IMGW_W-1:0] WIDTH_RST  = 11'd256;
  localparam logic [IMGH_W-1:0] HEIGHT_RST = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic dvld;
    logic pass_end;
  } rank_ctl_t;

  typedef struct packed {
    logic last_pass;
  } rank_sts_t;

endpackage

/* rtl/wmf_line_mem.sv */
module wmf_line_mem #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 16384
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/wmf_rank_sel.sv */
module wmf_rank_sel #(
  parameter int PIXEL_BITS = wmf_pkg::PIXEL_BITS_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wmf_pkg::rank_ctl_t         ctl,
  input  logic [PIXEL_BITS-1:0]      data,
  output wmf_pkg::rank_sts_t         sts,
  output logic [PIXEL_BITS-1:0]      value,
  output logic [wmf_pkg::CNT_W-1:0]  count
);

  localparam int BIT_W = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

  logic [BIT_W-1:0]          bit_r;
  logic                      first_r;
  logic [PIXEL_BITS-1:0]     prefix_r;
  logic [wmf_pkg::CNT_W-1:0] cnt_r;
  logic [wmf_pkg::CNT_W-1:0] n_r;
  logic [wmf_pkg::CNT_W-1:0] k_r;
  logic [PIXEL_BITS-1:0]     mask;
  logic                      hit;
  logic [wmf_pkg::CNT_W-1:0] k_cur;

  // count values below the candidate bit that share the known upper bits
  always_comb begin
    mask  = ({PIXEL_BITS{1'b1}} << bit_r) << 1;
    hit   = (((data ^ prefix_r) & mask) == '0) && !data[bit_r];
    k_cur = first_r ? (n_r >> 1) : k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r   <= '0;
      first_r <= 1'b1;
    end else if (ctl.start) begin
      bit_r    <= BIT_W'(PIXEL_BITS - 1);
      first_r  <= 1'b1;
      prefix_r <= '0;
      cnt_r    <= '0;
      n_r      <= '0;
    end else begin
      if (ctl.dvld) begin
        cnt_r <= cnt_r + wmf_pkg::CNT_W'(hit);
        if (first_r) begin
          n_r <= n_r + 1'b1;
        end
      end
      if (ctl.pass_end) begin
        if (k_cur >= cnt_r) begin
          prefix_r[bit_r] <= 1'b1;
          k_r             <= k_cur - cnt_r;
        end else begin
          k_r <= k_cur;
        end
        cnt_r   <= '0;
        first_r <= 1'b0;
        if (bit_r != '0) begin
          bit_r <= bit_r - 1'b1;
        end
      end
    end
  end

  assign sts.last_pass = (bit_r == '0);
  assign value         = prefix_r;
  assign count         = n_r;

endmodule

/* rtl/windowed_median_filter.sv */
// Square median filter over a grey image streamed in raster order.
// Input channel in_*: one request per grid position of a grid padded by
//   radius rows and columns; in_tuser[0] = pad, in_tuser[1] = frame_start.
// Output channel out_*: one request per image pixel, issued by grid items
//   whose row and column are both at least radius; out_tlast marks the
//   final pixel of the image.
// Config port cfg_*: radius, width and height; a write also returns the
//   raster position to the grid origin. Write only while the block is idle.
// An item that yields no result is accepted without leaving the idle state.
//   For an item with a result the median is found one bit per pass, each
//   pass reading the whole window through the single read port of the
//   line store; no new item is taken until its result enters the output register.
// The output register holds one finished result; a stalled receiver only
//   delays the next result, the block keeps accepting items meanwhile until
//   it needs the output register again.
// Reset: raster position to the origin, registers to radius 3 and a
//   256 x 256 image, output empty. Line store contents are not cleared; a
//   window only reads rows written earlier in the same frame.
`include "windowed_median_filter_macros.svh"

module windowed_median_filter #(
  parameter int MAX_RADIUS = wmf_pkg::MAX_RADIUS_D,
  parameter int MAX_WIDTH  = wmf_pkg::MAX_WIDTH_D,
  parameter int PIXEL_BITS = wmf_pkg::PIXEL_BITS_D,
  localparam int IN_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PIXEL_BITS + wmf_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,  // pixel
  input  logic [1:0]                    in_tuser,  // pad, frame_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata, // median_value, window_count
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
  localparam int RING_W    = $clog2(RING_ROWS);
  localparam int COL_AW    = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = RING_W + COL_AW;
  localparam int DEPTH     = RING_ROWS * (2 ** COL_AW);
  localparam int NROW_W    = $clog2(RING_ROWS + 1);
  localparam int ROW_W     = wmf_pkg::ROW_W;
  localparam int COL_W     = wmf_pkg::COL_W;

  logic [wmf_pkg::RAD_W-1:0]  radius_r;
  logic [wmf_pkg::IMGW_W-1:0] width_r;
  logic [wmf_pkg::IMGH_W-1:0] height_r;
  logic [ROW_W-1:0]           row_r;
  logic [COL_W-1:0]           col_r;
  logic [RING_W-1:0]          ring_r;

  wmf_pkg::state_t state_r, state_nxt;

  logic [RING_W-1:0] ring0_r, qring_r;
  logic [COL_W-1:0]  c0_r, c1_r, p_r;
  logic [NROW_W-1:0] nrows_r, rows_left_r;
  logic              fl_r;
  logic              rd_vld_r;

  logic                      out_valid_r;
  logic [PIXEL_BITS-1:0]     median_r;
  logic [wmf_pkg::CNT_W-1:0] count_r;
  logic                      last_r;

  logic [wmf_pkg::RAD_W-1:0]  rad;
  logic [wmf_pkg::IMGW_W-1:0] wid;
  logic [wmf_pkg::IMGH_W-1:0] hgt;
  logic [ROW_W-1:0] row_cur, rr, hm1, orow, r0, r1;
  logic [COL_W-1:0] col_cur, rc, wm1, ocol, c0, c1;
  logic [RING_W-1:0] ring_cur, dring, ring0;
  logic [NROW_W-1:0] nrows;
  logic pos_in_image, out_en, frame_last_c;
  logic accept;
  logic [PIXEL_BITS-1:0] wdata;

  logic                 mem_re;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [PIXEL_BITS-1:0] rdata;

  wmf_pkg::rank_ctl_t    rctl;
  wmf_pkg::rank_sts_t    rsts;
  logic [PIXEL_BITS-1:0] rank_value;
  logic [wmf_pkg::CNT_W-1:0] rank_count;

  logic load_out, addr_init, addr_reload, addr_step;

  // effective geometry and window bounds for the current grid position
  always_comb begin
    rad = (radius_r == '0) ? wmf_pkg::RAD_W'(1) :
          (int'(radius_r) > MAX_RADIUS) ? wmf_pkg::RAD_W'(MAX_RADIUS) : radius_r;
    wid = (width_r == '0) ? wmf_pkg::IMGW_W'(1) :
          (int'(width_r) > MAX_WIDTH) ? wmf_pkg::IMGW_W'(MAX_WIDTH) : width_r;
    hgt = (height_r == '0) ? wmf_pkg::IMGH_W'(1) : height_r;
    row_cur  = in_tuser[1] ? '0 : row_r;
    col_cur  = in_tuser[1] ? '0 : col_r;
    ring_cur = in_tuser[1] ? '0 : ring_r;
    rr  = ROW_W'(rad);
    rc  = COL_W'(rad);
    hm1 = ROW_W'(hgt) - 1'b1;
    wm1 = COL_W'(wid) - 1'b1;
    pos_in_image = (row_cur < ROW_W'(hgt)) && (col_cur < COL_W'(wid));
    out_en = (row_cur >= rr) && (col_cur >= rc);
    orow = row_cur - rr;
    ocol = col_cur - rc;
    r0 = (orow >= rr) ? orow - rr : '0;
    r1 = (orow + rr < hm1) ? orow + rr : hm1;
    c0 = (ocol >= rc) ? ocol - rc : '0;
    c1 = (ocol + rc < wm1) ? ocol + rc : wm1;
    nrows = NROW_W'(r1 - r0 + 1'b1);
    dring = RING_W'(row_cur - r0);
    ring0 = (ring_cur >= dring) ? ring_cur - dring
                                : ring_cur + RING_W'(RING_ROWS) - dring;
    frame_last_c = (orow == hm1) && (ocol == wm1);
    wdata = in_tuser[0] ? '0 : in_tdata[PIXEL_BITS-1:0];
  end

  assign accept = in_tvalid && in_tready;
  assign waddr  = {ring_cur, COL_AW'(col_cur)};
  assign raddr  = {qring_r, COL_AW'(p_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    mem_re        = 1'b0;
    rctl          = '0;
    load_out      = 1'b0;
    addr_init     = 1'b0;
    addr_reload   = 1'b0;
    addr_step     = 1'b0;
    case (state_r)
      wmf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && out_en) begin
          rctl.start = 1'b1;
          addr_init  = 1'b1;
          state_nxt  = wmf_pkg::ST_SCAN;
        end
      end
      wmf_pkg::ST_SCAN: begin
        mem_re    = 1'b1;
        addr_step = 1'b1;
        if (rows_left_r == NROW_W'(1) && p_r == c1_r) begin
          state_nxt = wmf_pkg::ST_DRAIN;
        end
      end
      wmf_pkg::ST_DRAIN: begin
        state_nxt = wmf_pkg::ST_STEP;
      end
      wmf_pkg::ST_STEP: begin
        rctl.pass_end = 1'b1;
        if (rsts.last_pass) begin
          state_nxt = wmf_pkg::ST_FINISH;
        end else begin
          addr_reload = 1'b1;
          state_nxt   = wmf_pkg::ST_SCAN;
        end
      end
      wmf_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = wmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmf_pkg::ST_IDLE;
      end
    endcase
    rctl.dvld = rd_vld_r;
  end

  // registers and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= wmf_pkg::RADIUS_RST;
      width_r  <= wmf_pkg::WIDTH_RST;
      height_r <= wmf_pkg::HEIGHT_RST;
      row_r    <= '0;
      col_r    <= '0;
      ring_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wmf_pkg::REG_RADIUS: radius_r <= cfg_wdata[wmf_pkg::RAD_W-1:0];
        wmf_pkg::REG_WIDTH:  width_r  <= cfg_wdata[wmf_pkg::IMGW_W-1:0];
        wmf_pkg::REG_HEIGHT: height_r <= cfg_wdata[wmf_pkg::IMGH_W-1:0];
        default: ;
      endcase
      if (cfg_index == wmf_pkg::REG_RADIUS || cfg_index == wmf_pkg::REG_WIDTH ||
          cfg_index == wmf_pkg::REG_HEIGHT) begin
        row_r  <= '0;
        col_r  <= '0;
        ring_r <= '0;
      end
    end else if (accept) begin
      if (col_cur + 1'b1 >= COL_W'(wid) + rc) begin
        col_r <= '0;
        if (row_cur + 1'b1 >= ROW_W'(hgt) + rr) begin
          row_r  <= '0;
          ring_r <= '0;
        end else begin
          row_r  <= row_cur + 1'b1;
          ring_r <= (ring_cur == RING_W'(RING_ROWS - 1)) ? '0 : ring_cur + 1'b1;
        end
      end else begin
        col_r  <= col_cur + 1'b1;
        row_r  <= row_cur;
        ring_r <= ring_cur;
      end
    end
  end

  // window address walk
  always_ff @(posedge clk) begin
    if (addr_init) begin
      ring0_r     <= ring0;
      c0_r        <= c0;
      c1_r        <= c1;
      nrows_r     <= nrows;
      fl_r        <= frame_last_c;
      qring_r     <= ring0;
      p_r         <= c0;
      rows_left_r <= nrows;
    end else if (addr_reload) begin
      qring_r     <= ring0_r;
      p_r         <= c0_r;
      rows_left_r <= nrows_r;
    end else if (addr_step) begin
      if (p_r == c1_r) begin
        p_r         <= c0_r;
        rows_left_r <= rows_left_r - 1'b1;
        qring_r     <= (qring_r == RING_W'(RING_ROWS - 1)) ? '0 : qring_r + 1'b1;
      end else begin
        p_r <= p_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_r <= rank_value;
      count_r  <= rank_count;
      last_r   <= fl_r;
    end
  end

  wmf_line_mem #(
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_line_mem (
    .clk   (clk),
    .we    (accept && pos_in_image),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  wmf_rank_sel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_rank_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .data  (rdata),
    .sts   (rsts),
    .value (rank_value),
    .count (rank_count)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({count_r, median_r});
  assign out_tlast  = last_r;

  `WMF_ASSERT_IMP(a_rd_in_scan, rd_vld_r,
                  state_r == wmf_pkg::ST_SCAN || state_r == wmf_pkg::ST_DRAIN)
  `WMF_ASSERT_IMP(a_step_drained, state_r == wmf_pkg::ST_STEP, !rd_vld_r)
  `WMF_ASSERT_NXT(a_no_result_idle, accept && !out_en, state_r == wmf_pkg::ST_IDLE)

endmodule
